>>> design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int DEN_IN_BITS  = OPERAND_BITS - 1;
  localparam int NUM_OUT_BITS = 33;
  localparam int DEN_OUT_BITS = 32;
  localparam int W            = 32;
  localparam int CNT_BITS     = 6;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_MUL,
    S_DIV,
    S_GCD,
    S_OUT
  } state_t;

  // sequencer steps; most store the last unit result and start the next unit run
  typedef enum logic [3:0] {
    P_FIRST,
    P_SECOND,
    P_DEN,
    P_QA,
    P_QB,
    P_LCM,
    P_TA,
    P_TB,
    P_SUM,
    P_RED,
    P_RNUM,
    P_RDEN,
    P_DONE
  } step_t;

  typedef struct packed {
    logic [1:0]                     operation;
    logic signed [OPERAND_BITS-1:0] a_num;
    logic [DEN_IN_BITS-1:0]         a_den;
    logic signed [OPERAND_BITS-1:0] b_num;
    logic [DEN_IN_BITS-1:0]         b_den;
  } in_t;

  typedef struct packed {
    logic signed [NUM_OUT_BITS-1:0] res_num;
    logic [DEN_OUT_BITS-1:0]        res_den;
    logic                           div_zero;
  } out_t;

endpackage

>>> design/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result to lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   in  channel: in_valid / in_ready / in_data (operation, a, b fractions).
//   out channel: out_valid / out_ready / out_data (res_num, res_den,
//   div_zero). One result per input transfer.
//   One item at a time: in_ready is high only while the unit is idle.
//   All arithmetic runs on one shared 32-bit datapath under a sequencer:
//   16-step shift-add multiplies, a binary gcd (one step per cycle, done
//   when one side reaches zero) and 32-step restoring divisions.
//   Time to out_valid varies with the operands, set by the gcd runs;
//   add/subtract runs two of them, multiply and nonzero divide one.
//   Division by a zero fraction gives 0/1 with div_zero set, going
//   from the S_STEP state straight to S_OUT with no unit run.
//   Reset (rst, synchronous) returns the unit to idle with no result.
//   If the receiver stalls, the result holds on out_data and no new item
//   is taken until it is transferred.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t state, state_next, step_state;
  step_t  phase, phase_next;

  op_t          op;
  logic         an, bn, rneg;
  logic [W-1:0] am, bm, ad, bd;
  logic [W-1:0] x, y;          // unit operands
  logic [W-1:0] acc, rem;      // unit result / division remainder
  logic [W-1:0] g, qa, qb, l, ta;
  logic [W-1:0] rmag, rden;
  logic [CNT_BITS-1:0] cnt;
  logic [CNT_BITS-1:0] shf;    // common power of two in gcd
  out_t         result;

  logic [W-1:0] ux, uy;
  logic [OPERAND_BITS-1:0] a_mag, b_mag;
  logic [NUM_OUT_BITS-1:0] fin_num;
  logic         tbn;
  logic         mul_last, div_last, gcd_done;

  logic [W:0] diff;
  assign diff = {1'b0, rem[W-2:0], x[W-1]} - {1'b0, y};

  assign a_mag    = in_data.a_num[OPERAND_BITS-1] ? -in_data.a_num : in_data.a_num;
  assign b_mag    = in_data.b_num[OPERAND_BITS-1] ? -in_data.b_num : in_data.b_num;
  assign fin_num  = rneg ? -{1'b0, rmag} : {1'b0, rmag};
  assign tbn      = (op == OP_SUB) ? !bn : bn;
  assign mul_last = (cnt == CNT_BITS'(OPERAND_BITS - 1));
  assign div_last = (cnt == CNT_BITS'(W - 1));
  assign gcd_done = (x == '0) || (y == '0);

  // step decode: which unit runs next and on what
  always_comb begin
    step_state = S_STEP;
    phase_next = phase;
    ux         = '0;
    uy         = '0;
    case (phase)
      P_FIRST: begin
        if (op == OP_MUL) begin
          step_state = S_MUL; ux = am; uy = bm; phase_next = P_SECOND;
        end else if (op == OP_DIV) begin
          if (bm == '0) begin
            step_state = S_OUT; phase_next = P_FIRST;
          end else begin
            step_state = S_MUL; ux = am; uy = bd; phase_next = P_SECOND;
          end
        end else begin
          step_state = S_GCD; ux = ad; uy = bd; phase_next = P_QA;
        end
      end
      P_SECOND: begin
        step_state = S_MUL; ux = ad; uy = (op == OP_MUL) ? bd : bm;
        phase_next = P_DEN;
      end
      P_DEN:    phase_next = P_RED;
      P_QA:     begin step_state = S_DIV; ux = ad; uy = acc; phase_next = P_QB; end
      P_QB:     begin step_state = S_DIV; ux = bd; uy = g; phase_next = P_LCM; end
      P_LCM:    begin step_state = S_MUL; ux = ad; uy = acc; phase_next = P_TA; end
      P_TA:     begin step_state = S_MUL; ux = am; uy = qb; phase_next = P_TB; end
      P_TB:     begin step_state = S_MUL; ux = bm; uy = qa; phase_next = P_SUM; end
      P_SUM:    phase_next = P_RED;
      P_RED:    begin step_state = S_GCD; ux = rmag; uy = rden; phase_next = P_RNUM; end
      P_RNUM:   begin step_state = S_DIV; ux = rmag; uy = acc; phase_next = P_RDEN; end
      P_RDEN:   begin step_state = S_DIV; ux = rden; uy = g; phase_next = P_DONE; end
      P_DONE:   begin step_state = S_OUT; phase_next = P_FIRST; end
      default: begin
        step_state = S_IDLE; phase_next = P_FIRST;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_STEP;
      S_STEP:  state_next = step_state;
      S_MUL:   if (mul_last) state_next = S_STEP;
      S_DIV:   if (div_last) state_next = S_STEP;
      S_GCD:   if (gcd_done) state_next = S_STEP;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    out_data  = result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= P_FIRST;
      result <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= op_t'(in_data.operation);
            an <= in_data.a_num[OPERAND_BITS-1];
            bn <= in_data.b_num[OPERAND_BITS-1];
            am <= W'(a_mag);
            bm <= W'(b_mag);
            ad <= (in_data.a_den == '0) ? W'(1) : W'(in_data.a_den);
            bd <= (in_data.b_den == '0) ? W'(1) : W'(in_data.b_den);
          end
        end
        S_STEP: begin
          phase <= phase_next;
          x     <= ux;
          y     <= uy;
          acc   <= '0;
          rem   <= '0;
          cnt   <= '0;
          shf   <= '0;
          case (phase)
            P_FIRST: begin
              rneg <= an ^ bn;
              if (op == OP_DIV && bm == '0) begin
                result <= '{res_num: '0, res_den: DEN_OUT_BITS'(1), div_zero: 1'b1};
              end
            end
            P_SECOND: rmag <= acc;
            P_DEN:    rden <= acc;
            P_QA:     g <= acc;
            P_QB:     qa <= acc;
            P_LCM:    qb <= acc;
            P_TA:     l <= acc;
            P_TB:     ta <= acc;
            P_SUM: begin
              // acc holds tb
              rden <= l;
              if (an == tbn) begin
                rmag <= ta + acc; rneg <= an;
              end else if (ta >= acc) begin
                rmag <= ta - acc; rneg <= an;
              end else begin
                rmag <= acc - ta; rneg <= tbn;
              end
            end
            P_RED:    ;
            P_RNUM:   g <= acc;
            P_RDEN:   rmag <= acc;
            P_DONE: begin
              result <= '{res_num: fin_num, res_den: acc, div_zero: 1'b0};
            end
            default: ;
          endcase
        end
        // shift-add multiply, 16 steps
        S_MUL: begin
          acc <= acc + (y[0] ? x : '0);
          x   <= {x[W-2:0], 1'b0};
          y   <= {1'b0, y[W-1:1]};
          cnt <= cnt + CNT_BITS'(1);
        end
        // restoring divide x / y, 32 steps
        S_DIV: begin
          if (!diff[W]) rem <= diff[W-1:0];
          else          rem <= {rem[W-2:0], x[W-1]};
          x   <= {x[W-2:0], !diff[W]};
          acc <= {x[W-2:0], !diff[W]};
          cnt <= cnt + CNT_BITS'(1);
        end
        // binary gcd
        S_GCD: begin
          if (gcd_done) begin
            acc <= ((x == '0) ? y : x) << shf;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1; y <= y >> 1; shf <= shf + CNT_BITS'(1);
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x >= y) begin
            x <= (x - y) >> 1;
          end else begin
            y <= (y - x) >> 1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.res_den != '0)
    else $error("zero denominator");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.div_zero |-> out_data.res_num == '0 &&
      out_data.res_den == DEN_OUT_BITS'(1))
    else $error("bad divide-by-zero result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

>>> tb/rational_arithmetic_unit_tb.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Drives fraction pairs with all four operations through the valid/ready
// input channel, predicts each reduced result and checks every output
// transfer against it, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int MAX_CYCLES = 2000000;
  localparam int RANDOM_ITEMS = 900;

  typedef struct {
    in_t  stim;
    logic known;
    out_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  out_t expected_q[$];
  int   errors = 0;
  int   cycles = 0;
  logic stim_done = 1'b0;

  rational_arithmetic_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_t reduce_fraction(in_t s);
    out_t r;
    logic an, bn, rneg, tbn;
    longint unsigned am, bm, ad, bd, rmag, rden, g, l, ta, tb;
    an = s.a_num[OPERAND_BITS-1];
    bn = s.b_num[OPERAND_BITS-1];
    am = an ? longint'(-int'(s.a_num)) : longint'(s.a_num);
    bm = bn ? longint'(-int'(s.b_num)) : longint'(s.b_num);
    ad = (s.a_den == 0) ? 1 : s.a_den;
    bd = (s.b_den == 0) ? 1 : s.b_den;
    rneg = 1'b0;
    rmag = 0;
    rden = 1;
    r = '0;
    case (op_t'(s.operation))
      OP_MUL: begin
        rmag = am * bm;
        rden = ad * bd;
        rneg = an ^ bn;
      end
      OP_DIV: begin
        if (bm == 0) begin
          r.div_zero = 1'b1;
        end else begin
          rmag = am * bd;
          rden = ad * bm;
          rneg = an ^ bn;
        end
      end
      default: begin
        l = (ad / gcd64(ad, bd)) * bd;
        ta = am * (l / ad);
        tb = bm * (l / bd);
        tbn = (op_t'(s.operation) == OP_SUB) ? !bn : bn;
        if (an == tbn) begin
          rmag = ta + tb;
          rneg = an;
        end else if (ta >= tb) begin
          rmag = ta - tb;
          rneg = an;
        end else begin
          rmag = tb - ta;
          rneg = tbn;
        end
        rden = l;
      end
    endcase
    g = gcd64(rmag, rden);
    if (g != 0) begin
      rmag = rmag / g;
      rden = rden / g;
    end
    if (rmag == 0) begin
      rneg = 1'b0;
      rden = 1;
    end
    r.res_num = rneg ? -rmag[NUM_OUT_BITS-1:0] : rmag[NUM_OUT_BITS-1:0];
    r.res_den = rden[DEN_OUT_BITS-1:0];
    return r;
  endfunction

  function automatic in_t mk(op_t op, int an, int ad, int bn, int bd);
    in_t s;
    s.operation = op;
    s.a_num = an[OPERAND_BITS-1:0];
    s.a_den = ad[DEN_IN_BITS-1:0];
    s.b_num = bn[OPERAND_BITS-1:0];
    s.b_den = bd[DEN_IN_BITS-1:0];
    return s;
  endfunction

  function automatic out_t res(longint n, longint unsigned d, logic z);
    out_t r;
    r.res_num = n[NUM_OUT_BITS-1:0];
    r.res_den = d[DEN_OUT_BITS-1:0];
    r.div_zero = z;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
    return $urandom_range(0, 4);
  endfunction

  function automatic in_t random_item();
    in_t s;
    s = in_t'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: s.b_num = '0;
      1: begin
        s.a_den = DEN_IN_BITS'($urandom_range(1, 12));
        s.b_den = DEN_IN_BITS'($urandom_range(1, 12));
      end
      2: s.a_num = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3: s.b_den = s.a_den;
      default: ;
    endcase
    if ($urandom_range(0, 40) == 0) s.a_den = '0;
    if ($urandom_range(0, 40) == 0) s.b_den = '0;
    return s;
  endfunction

  task automatic send(in_t s, logic known, out_t r);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    expected_q.push_back(known ? r : reduce_fraction(s));
    in_data <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    dir_row_t dir[$];
    dir.push_back('{mk(OP_MUL, 0, 1, 0, 1), 1'b1, res(0, 1, 0)});
    dir.push_back('{mk(OP_DIV, 5, 3, 0, 7), 1'b1, res(0, 1, 1)});
    dir.push_back('{mk(OP_DIV, -32768, 1, 0, 32767), 1'b1, res(0, 1, 1)});
    dir.push_back('{mk(OP_MUL, -32768, 1, -32768, 1), 1'b1, res(64'd1073741824, 1, 0)});
    dir.push_back('{mk(OP_MUL, 32767, 1, -32768, 1), 1'b1, res(-64'sd1073709056, 1, 0)});
    dir.push_back('{mk(OP_ADD, -32768, 1, -32768, 1), 1'b1, res(-65536, 1, 0)});
    dir.push_back('{mk(OP_SUB, 32767, 1, -32768, 1), 1'b1, res(65535, 1, 0)});
    dir.push_back('{mk(OP_SUB, 7, 3, 7, 3), 1'b1, res(0, 1, 0)});
    dir.push_back('{mk(OP_ADD, 1, 0, 1, 0), 1'b1, res(2, 1, 0)});
    dir.push_back('{mk(OP_MUL, 1, 32767, 1, 32767), 1'b1, res(1, 64'd1073676289, 0)});
    dir.push_back('{mk(OP_DIV, 1, 32767, 32767, 1), 1'b1, res(1, 64'd1073676289, 0)});
    dir.push_back('{mk(OP_DIV, -3, 4, -9, 8), 1'b0, '0});
    dir.push_back('{mk(OP_ADD, 1, 32767, 1, 32766), 1'b0, '0});
    dir.push_back('{mk(OP_SUB, -5, 6, 7, 10), 1'b0, '0});
    dir.push_back('{mk(OP_ADD, 3, 4, -5, 6), 1'b0, '0});
    dir.push_back('{mk(OP_MUL, 6, 4, -10, 15), 1'b0, '0});
    dir.push_back('{mk(OP_SUB, 32767, 32767, -32768, 32767), 1'b0, '0});
    dir.push_back('{mk(OP_DIV, 12, 32767, -32768, 3), 1'b0, '0});
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir[i]) send(dir[i].stim, dir[i].known, dir[i].res);
    repeat (RANDOM_ITEMS) send(random_item(), 1'b0, '0);
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if ($urandom_range(0, 9) < 2) out_ready <= 1'b0;
    else if ($urandom_range(0, 49) == 0) out_ready <= 1'b0;
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: %h", out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.res_num !== e.res_num) begin
          $error("res_num expected %0d actual %0d", e.res_num, out_data.res_num);
          errors++;
        end
        if (out_data.res_den !== e.res_den) begin
          $error("res_den expected %0d actual %0d", e.res_den, out_data.res_den);
          errors++;
        end
        if (out_data.div_zero !== e.div_zero) begin
          $error("div_zero expected %0b actual %0b", e.div_zero, out_data.div_zero);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && expected_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
